@@ src/field_25519_mod_arith_defines.svh @@
// Assertion macros for the modular arithmetic unit over 2^255-19.
`ifndef FIELD_25519_MOD_ARITH_DEFINES_SVH
`define FIELD_25519_MOD_ARITH_DEFINES_SVH
`ifndef SYNTHESIS
`define F25519_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("f25519 assertion failed");
`define F25519_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("f25519 assertion failed");
`else
`define F25519_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define F25519_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/f25519_pkg.sv @@
// Package: constants and action codes of the modular arithmetic unit.
`timescale 1ns / 1ps
package f25519_pkg;
  localparam int NumLimbsDef = 9;
  localparam int LimbBitsDef = 30;
  localparam int FoldPos = 255;
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_INT = 2'd3;
endpackage

@@ src/field_25519_mod_arith.sv @@
// Top level: modular add, subtract, multiply and integer reduction modulo 2^255-19.
// Sequence: operation starts on the marked limb; the operand memories are read,
// a dispatch state follows, a multiply runs on one limb multiplier, folding reduces
// the result, then NUM_LIMBS result limbs leave one per cycle while out_stall_i is low.
// Throughput: one operation at a time; input stalls from the marked limb to the last result.
// Reset: asynchronous, active low; clears control state, operand memories need none.
`timescale 1ns / 1ps
`include "field_25519_mod_arith_defines.svh"
module field_25519_mod_arith
  import f25519_pkg::*;
#(
  parameter int NUM_LIMBS = NumLimbsDef,
  parameter int LIMB_BITS = LimbBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [LIMB_BITS-1:0] x_limb_i,
  input  logic [LIMB_BITS-1:0] y_limb_i,
  input  logic signed [63:0]   int_value_i,
  input  logic                 last_limb_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LIMB_BITS-1:0] result_limb_o,
  output logic                 last_result_o,
  output logic                 extra_limbs_o
);

  localparam int CW  = $clog2(NUM_LIMBS + 1);
  localparam int AW  = $clog2(NUM_LIMBS);
  localparam int IW  = $clog2(NUM_LIMBS + 1);
  localparam int KW  = $clog2(2 * NUM_LIMBS);
  localparam int OPW = NUM_LIMBS * LIMB_BITS;
  localparam int WW  = 2 * NUM_LIMBS * LIMB_BITS;
  localparam int PW  = 2 * LIMB_BITS;
  localparam int ACW = 2 * LIMB_BITS + 6;
  localparam int SUB_SH = OPW - FoldPos + 1;
  localparam logic [WW-1:0] LOW_MASK = (WW'(1) << FoldPos) - WW'(1);
  localparam logic [WW-1:0] PRIME    = (WW'(1) << FoldPos) - WW'(19);
  localparam logic [WW-1:0] SUB_K    = PRIME << SUB_SH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DISP = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FOLD = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]           state_q;
  logic [CW-1:0]        cnt_q, cop_q, ld_q, ridx_q, ocnt_q;
  logic                 ovf_q, xovf_q, rv_q;
  logic [LIMB_BITS-1:0] mem_x [NUM_LIMBS];
  logic [LIMB_BITS-1:0] mem_y [NUM_LIMBS];
  logic [LIMB_BITS-1:0] rd_x_q, rd_y_q;
  logic [AW-1:0]        rd_addr;
  logic [1:0]           act_q;
  logic [63:0]          ival_q;
  logic [OPW-1:0]       a_q, b_q;
  logic [WW-1:0]        w_q, hi, fold;
  logic [KW-1:0]        k_q, k_nx, jdx;
  logic [IW-1:0]        i_q, hi_i, lo_nx;
  logic                 mrun_q, pv_q, pend_q, plast_q, col_end, k_last, rng;
  logic [AW-1:0]        a_idx, b_idx;
  logic [LIMB_BITS-1:0] a_limb, b_limb;
  logic [PW-1:0]        prod_q;
  logic [ACW-1:0]       acc_q, acc_s;
  logic                 in_acc, out_acc;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i & ~in_stall_o;
  assign out_valid_o   = (state_q == ST_EMIT);
  assign out_acc       = out_valid_o & ~out_stall_i;
  assign result_limb_o = w_q[LIMB_BITS-1:0];
  assign last_result_o = (ocnt_q == CW'(NUM_LIMBS - 1));
  assign extra_limbs_o = xovf_q;

  assign rd_addr = (ld_q < CW'(NUM_LIMBS)) ? ld_q[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc && (cnt_q < CW'(NUM_LIMBS))) begin
      mem_x[cnt_q[AW-1:0]] <= x_limb_i;
      mem_y[cnt_q[AW-1:0]] <= y_limb_i;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  assign k_nx    = k_q + KW'(1);
  assign lo_nx   = (k_nx >= KW'(NUM_LIMBS)) ? IW'(k_nx - KW'(NUM_LIMBS - 1)) : '0;
  assign hi_i    = (k_q < KW'(NUM_LIMBS)) ? IW'(k_q) : IW'(NUM_LIMBS - 1);
  assign col_end = (i_q >= hi_i);
  assign k_last  = (k_q == KW'(2 * NUM_LIMBS - 1));
  assign jdx     = k_q - KW'(i_q);
  assign rng     = (i_q < IW'(NUM_LIMBS)) && (jdx < KW'(NUM_LIMBS));
  assign a_idx   = (i_q < IW'(NUM_LIMBS)) ? i_q[AW-1:0] : '0;
  assign b_idx   = (jdx < KW'(NUM_LIMBS)) ? jdx[AW-1:0] : '0;
  assign a_limb  = a_q[a_idx*LIMB_BITS +: LIMB_BITS];
  assign b_limb  = b_q[b_idx*LIMB_BITS +: LIMB_BITS];
  assign acc_s   = acc_q + ACW'(prod_q);

  assign hi   = w_q >> FoldPos;
  assign fold = (w_q & LOW_MASK) + (hi << 4) + (hi << 1) + hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      xovf_q  <= 1'b0;
      ld_q    <= '0;
      rv_q    <= 1'b0;
      ocnt_q  <= '0;
      k_q     <= '0;
      i_q     <= '0;
      mrun_q  <= 1'b0;
      pv_q    <= 1'b0;
      pend_q  <= 1'b0;
      plast_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (last_limb_i) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              xovf_q  <= ovf_q | (cnt_q == CW'(NUM_LIMBS));
              ld_q    <= '0;
              state_q <= ST_LOAD;
            end else if (cnt_q < CW'(NUM_LIMBS)) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        ST_LOAD: begin
          if (ld_q < CW'(NUM_LIMBS)) ld_q <= ld_q + CW'(1);
          rv_q <= (ld_q < CW'(NUM_LIMBS));
          if (rv_q && (ridx_q == CW'(NUM_LIMBS - 1))) state_q <= ST_DISP;
        end
        ST_DISP: begin
          k_q <= '0;
          i_q <= '0;
          if (act_q == ACT_MUL) begin
            mrun_q  <= 1'b1;
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_FOLD;
          end
        end
        ST_MUL: begin
          pv_q <= mrun_q;
          if (mrun_q) begin
            pend_q  <= col_end;
            plast_q <= col_end & k_last;
            if (col_end) begin
              k_q <= k_nx;
              i_q <= lo_nx;
              if (k_last) mrun_q <= 1'b0;
            end else begin
              i_q <= i_q + IW'(1);
            end
          end
          if (pv_q && pend_q && plast_q) state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          if (hi == '0) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (ocnt_q == CW'(NUM_LIMBS - 1)) begin
              ocnt_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              ocnt_q <= ocnt_q + CW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ld_q;
    if (in_acc && last_limb_i) begin
      act_q  <= action_i;
      ival_q <= int_value_i;
      cop_q  <= (cnt_q < CW'(NUM_LIMBS)) ? cnt_q + CW'(1) : cnt_q;
    end
    case (state_q)
      ST_LOAD: begin
        if (rv_q) begin
          a_q <= {(ridx_q < cop_q) ? rd_x_q : '0, a_q[OPW-1:LIMB_BITS]};
          b_q <= {(ridx_q < cop_q) ? rd_y_q : '0, b_q[OPW-1:LIMB_BITS]};
        end
      end
      ST_DISP: begin
        acc_q <= '0;
        case (act_q)
          ACT_ADD: w_q <= WW'(a_q) + WW'(b_q);
          ACT_SUB: w_q <= SUB_K + WW'(a_q) - WW'(b_q);
          ACT_MUL: w_q <= '0;
          default: w_q <= SUB_K + {{(WW-64){ival_q[63]}}, ival_q};
        endcase
      end
      ST_MUL: begin
        if (mrun_q) prod_q <= rng ? ({{LIMB_BITS{1'b0}}, a_limb} *
                                     {{LIMB_BITS{1'b0}}, b_limb}) : '0;
        if (pv_q) begin
          if (pend_q) begin
            w_q   <= {acc_s[LIMB_BITS-1:0], w_q[WW-1:LIMB_BITS]};
            acc_q <= acc_s >> LIMB_BITS;
          end else begin
            acc_q <= acc_s;
          end
        end
      end
      ST_FOLD: begin
        if (hi != '0) w_q <= fold;
        else if (w_q >= PRIME) w_q <= w_q - PRIME;
      end
      ST_EMIT: begin
        if (out_acc) w_q <= w_q >> LIMB_BITS;
      end
      default: begin
      end
    endcase
  end

  `F25519_ASSERT_IMP(a_emit_stalls_in, clk_i, rst_ni, out_valid_o, in_stall_o)
  `F25519_ASSERT_NXT(a_start_stalls, clk_i, rst_ni, in_acc && last_limb_i, in_stall_o)
  `F25519_ASSERT_NXT(a_last_ends, clk_i, rst_ni, out_acc && last_result_o, !out_valid_o)
  `F25519_ASSERT_IMP(a_result_reduced, clk_i, rst_ni, out_valid_o, w_q < PRIME)

endmodule

@@ dv/testbench.sv @@
// Testbench for the modular arithmetic unit over 2^255-19: driver, monitor and scoreboard.
`timescale 1ns / 1ps
module testbench;
  import f25519_pkg::*;

  localparam int NL = NumLimbsDef;
  localparam int LB = LimbBitsDef;
  localparam int MaxCycles = 2000000;
  localparam logic [543:0] PrimeVal = (544'd1 << 255) - 544'd19;

  typedef struct {
    logic [1:0]         act;
    logic [LB-1:0]      x;
    logic [LB-1:0]      y;
    logic signed [63:0] ival;
    logic               last;
    bit                 pause;
  } limb_item_t;

  typedef struct {
    logic [LB-1:0] limb;
    logic          last;
    logic          extra;
  } field_limb_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_ADD;
  logic [LB-1:0]      x_limb = '0;
  logic [LB-1:0]      y_limb = '0;
  logic signed [63:0] int_value = '0;
  logic               last_limb = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LB-1:0]      result_limb;
  logic               last_result;
  logic               extra_limbs;

  limb_item_t  pending_limbs[$];
  field_limb_t expected_limbs[$];
  logic [LB-1:0] x_store[NL];
  logic [LB-1:0] y_store[NL];
  int  stored_count = 0;
  bit  overflow_flag = 1'b0;
  bit  in_taken = 1'b0;
  bit  rst_done = 1'b0;
  int  sent_count = 0;
  int  op_count = 0;
  int  result_count = 0;
  int  error_count = 0;
  longint cycle_count = 0;

  field_25519_mod_arith u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .x_limb_i(x_limb), .y_limb_i(y_limb),
    .int_value_i(int_value), .last_limb_i(last_limb),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_limb_o(result_limb), .last_result_o(last_result),
    .extra_limbs_o(extra_limbs)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic push_limb(input logic [1:0] act, input logic [LB-1:0] x,
                           input logic [LB-1:0] y, input logic signed [63:0] iv,
                           input logic last);
    limb_item_t it;
    it.act = act; it.x = x; it.y = y; it.ival = iv; it.last = last; it.pause = 1'b0;
    pending_limbs.push_back(it);
  endtask

  function automatic logic [543:0] operand_value(input bit second);
    logic [543:0] v;
    v = '0;
    for (int i = NL - 1; i >= 0; i--) v = (v << LB) | (second ? y_store[i] : x_store[i]);
    return v;
  endfunction

  task automatic predict_field_result(input limb_item_t it);
    logic [543:0] a, b, r;
    field_limb_t e;
    if (stored_count < NL) begin
      x_store[stored_count] = it.x;
      y_store[stored_count] = it.y;
      stored_count++;
    end else begin
      overflow_flag = 1'b1;
    end
    if (it.last) begin
      a = operand_value(1'b0);
      b = operand_value(1'b1);
      case (it.act)
        ACT_ADD: r = (a + b) % PrimeVal;
        ACT_SUB: r = ((a % PrimeVal) + PrimeVal - (b % PrimeVal)) % PrimeVal;
        ACT_MUL: r = (a * b) % PrimeVal;
        default: begin
          if (it.ival < 0) r = PrimeVal - 544'($unsigned(-it.ival));
          else r = 544'($unsigned(it.ival));
          r = r % PrimeVal;
        end
      endcase
      for (int i = 0; i < NL; i++) begin
        e.limb = r[i*LB +: LB];
        e.last = (i == NL - 1);
        e.extra = overflow_flag;
        expected_limbs.push_back(e);
      end
      op_count++;
      for (int i = 0; i < NL; i++) begin
        x_store[i] = '0;
        y_store[i] = '0;
      end
      stored_count = 0;
      overflow_flag = 1'b0;
    end
  endtask

  function automatic int sender_idle_pct();
    return sent_count < 80 ? 8 : (sent_count < 160 ? 76 : 0);
  endfunction

  function automatic int receiver_stall_pct();
    return sent_count < 80 ? 76 : (sent_count < 160 ? 8 : 0);
  endfunction

  always @(negedge clk_i) begin
    if (rst_done) begin
      if (!in_valid || in_taken) begin
        if (pending_limbs.size() > 0 && pending_limbs[0].pause) begin
          in_valid <= 1'b0;
          if (expected_limbs.size() == 0) void'(pending_limbs.pop_front());
        end else if (pending_limbs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_valid  <= 1'b1;
          action    <= pending_limbs[0].act;
          x_limb    <= pending_limbs[0].x;
          y_limb    <= pending_limbs[0].y;
          int_value <= pending_limbs[0].ival;
          last_limb <= pending_limbs[0].last;
          void'(pending_limbs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct());
    end
  end

  always @(posedge clk_i) begin
    limb_item_t it;
    field_limb_t e;
    cycle_count++;
    in_taken <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      it.act = action; it.x = x_limb; it.y = y_limb; it.ival = int_value;
      it.last = last_limb; it.pause = 1'b0;
      predict_field_result(it);
      sent_count++;
    end
    if (out_valid && !out_stall) begin
      result_count++;
      if (expected_limbs.size() == 0) begin
        report_mismatch("unexpected result limb", 64'(result_limb), 64'd0);
      end else begin
        e = expected_limbs.pop_front();
        if (result_limb !== e.limb)
          report_mismatch("result_limb", 64'(result_limb), 64'(e.limb));
        if (last_result !== e.last)
          report_mismatch("last_result", 64'(last_result), 64'(e.last));
        if (extra_limbs !== e.extra)
          report_mismatch("extra_limbs", 64'(extra_limbs), 64'(e.extra));
      end
    end
    if (cycle_count > MaxCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    limb_item_t pause_item;
    logic [543:0] pv;
    int n;
    logic [1:0] act;
    pv = PrimeVal;
    pause_item.act = ACT_ADD; pause_item.x = '0; pause_item.y = '0; pause_item.ival = '0;
    pause_item.last = 1'b0; pause_item.pause = 1'b1;
    for (int i = 0; i < NL; i++) begin
      x_store[i] = '0;
      y_store[i] = '0;
    end

    push_limb(ACT_ADD, '1, '1, 64'sd0, 1'b1);
    push_limb(ACT_SUB, '0, '1, 64'sd0, 1'b1);
    push_limb(ACT_MUL, '1, '1, 64'sd0, 1'b1);
    push_limb(ACT_INT, '1, '1, 64'sh8000000000000000, 1'b1);
    push_limb(ACT_INT, '0, '0, 64'sh7fffffffffffffff, 1'b1);
    push_limb(ACT_INT, '0, '0, -64'sd1, 1'b1);
    push_limb(ACT_INT, '0, '0, 64'sd0, 1'b1);
    for (int i = 0; i < NL; i++) push_limb(ACT_INT, '1, '1, 64'sd0, i == NL - 1);
    for (int i = 0; i < NL; i++) push_limb(ACT_SUB, pv[i*LB +: LB], '1, 64'sd0, i == NL - 1);
    pending_limbs.push_back(pause_item);
    for (int i = 0; i < NL; i++) push_limb(ACT_MUL, '1, pv[i*LB +: LB], 64'sd0, i == NL - 1);
    for (int i = 0; i < NL + 2; i++) push_limb(ACT_ADD, '1, '1, 64'sd0, i == NL + 1);

    while (pending_limbs.size() < 230) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(NL + 3, NL + 1) : $urandom_range(NL, 1);
      act = 2'($urandom_range(3));
      for (int i = 0; i < n; i++) begin
        logic [LB-1:0] xv, yv;
        xv = LB'($urandom); yv = LB'($urandom);
        if ($urandom_range(7) == 0) xv = '1;
        if ($urandom_range(7) == 0) yv = '0;
        push_limb((i == n - 1) ? act : 2'($urandom_range(3)), xv, yv,
                  {$urandom, $urandom}, i == n - 1);
      end
      if ($urandom_range(15) == 0) pending_limbs.push_back(pause_item);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    rst_done = 1'b1;
    wait (pending_limbs.size() == 0 && !in_valid && expected_limbs.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d limb transactions, %0d operations, %0d result limbs",
             sent_count, op_count, result_count);
    if (error_count == 0 && expected_limbs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
